// ----- hw/rtl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque: command and result items,
// action codes, status codes and the per-cycle control word for the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  // action codes of a command item
  typedef enum logic [2:0] {
    ACT_CLEAR      = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5
  } action_t;

  // status codes of a result item
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // command item
  typedef struct packed {
    action_t            action;
    logic signed [31:0] value;
  } cmd_t;

  // result item
  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic [4:0]         count;
  } result_t;

  // per-cycle operation broadcast to every cell, already qualified
  typedef struct packed {
    logic clear;
    logic push_front;
    logic push_back;
    logic pop_front;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cdq_cell.sv -----
// ----------------------------------------------------------------------------
// cdq_cell
// One slot of the deque chain. Holds a word and an occupied flag, takes its
// left neighbor on a push at the front, its right neighbor on a pop, and the
// pushed word when it is the first free slot on a push at the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_cell
  import cdq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cell_ctl_t          ctl,
  input  wire logic signed [31:0] value,
  input  wire logic signed [31:0] left_word,
  input  wire logic               left_vld,
  input  wire logic signed [31:0] right_word,
  input  wire logic               right_vld,
  output logic signed [31:0]      word,
  output logic                    vld
);

  // first free slot: the neighbor toward the front is occupied, this one not
  logic tail_slot;
  assign tail_slot = left_vld & ~vld;

  // occupied flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.clear) begin
      vld <= 1'b0;
    end else if (ctl.push_front) begin
      vld <= left_vld;
    end else if (ctl.pop_front) begin
      vld <= right_vld;
    end else if (ctl.push_back && tail_slot) begin
      vld <= 1'b1;
    end
  end

  // stored word
  always_ff @(posedge clk) begin
    if (ctl.push_front) begin
      word <= left_word;
    end else if (ctl.pop_front) begin
      word <= right_word;
    end else if (ctl.push_back && tail_slot) begin
      word <= value;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/circular_deque.sv -----
// Circular deque built as a chain of DEPTH slot cells, front item in cell 0.
// The result item is registered and appears in the cycle after the command item is taken.
// Throughput: one item per cycle; busy stays low, every action is a single
// shift or write along the chain.
// Reset: rst empties the deque (count zero); stored words keep stale data.
// The receiver cannot stall: each result strobe lasts one cycle.
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed words with clear, push/pop/peek at the front
// and push/peek at the back; full and empty requests are refused.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd,
  output logic      valid,
  output result_t   result
);

  localparam int CW = $clog2(DEPTH + 1);

  // chain wiring
  logic signed [31:0] word [DEPTH];
  logic               vld  [DEPTH];

  cell_ctl_t          ctl;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic signed [31:0] back_word;
  logic signed [31:0] back_word_next;
  logic signed [31:0] data_next;
  logic [1:0]         status_next;
  logic               accept;
  logic               full;
  logic               empty;
  logic [CW+4:0]      count_ext;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign full   = vld[DEPTH-1];
  assign empty  = ~vld[0];

  // row of slot cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] lw;
    logic               lv;
    logic signed [31:0] rw;
    logic               rv;

    if (i == 0) begin : g_head
      assign lw = cmd.value;
      assign lv = 1'b1;
    end else begin : g_mid
      assign lw = word[i-1];
      assign lv = vld[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rw = '0;
      assign rv = 1'b0;
    end else begin : g_body
      assign rw = word[i+1];
      assign rv = vld[i+1];
    end

    cdq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .value      (cmd.value),
      .left_word  (lw),
      .left_vld   (lv),
      .right_word (rw),
      .right_vld  (rv),
      .word       (word[i]),
      .vld        (vld[i])
    );
  end

  // action decode
  always_comb begin
    ctl            = '0;
    data_next      = '0;
    status_next    = ST_DONE;
    count_next     = count;
    back_word_next = back_word;
    case (cmd.action)
      ACT_CLEAR: begin
        ctl.clear  = 1'b1;
        count_next = '0;
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.push_front = 1'b1;
          count_next     = count + 1'b1;
          if (empty) begin
            back_word_next = cmd.value;
          end
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.push_back  = 1'b1;
          count_next     = count + 1'b1;
          back_word_next = cmd.value;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.pop_front = 1'b1;
          data_next     = word[0];
          count_next    = count - 1'b1;
        end
      end
      ACT_PEEK_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          data_next = word[0];
        end
      end
      ACT_PEEK_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          data_next = back_word;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctl = '0;
    end
  end

  // item count, masked to the result field width
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  assign count_ext = (CW + 5)'(count_next);

  // copy of the back item, so a peek at the back needs no chain search
  always_ff @(posedge clk) begin
    if (accept) begin
      back_word <= back_word_next;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result.data   <= data_next;
      result.status <= status_next;
      result.count  <= count_ext[4:0];
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_circular_deque.sv -----
// ----------------------------------------------------------------------------
// tb_circular_deque
// Self-checking bench for the circular deque. Commands are sent through the
// start/busy handshake and a behavioral ring model predicts every result
// item, which is compared field by field as the strobed results arrive.
// Directed cases cover the empty and full refusals, value extremes and
// unused action codes. Random traffic alternates between filling and
// draining bursts under three sender idling profiles.
// ----------------------------------------------------------------------------
module tb_circular_deque;
  import cdq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 60000;
  localparam int TAIL_CYCLES = 4;

  // action codes the block must treat as no-ops
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    valid;
  result_t result;

  // behavioral ring state
  logic signed [31:0] ring_words [DEPTH];
  int                 front_ptr;
  int                 back_ptr;
  int                 held_count;

  result_t pending_results [$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      sender_idle_pct = 0;

  circular_deque #(.DEPTH(DEPTH)) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .valid (valid),
    .result(result)
  );

  // clock
  always #1 clk = ~clk;

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int ring_next(int p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic int ring_prev(int p);
    return (p == 0) ? DEPTH - 1 : p - 1;
  endfunction

  // apply one command to the ring model and return the expected result
  function automatic result_t deque_predict(cmd_t c);
    result_t r;
    logic    is_full;
    logic    is_empty;
    r.data = '0;
    r.status = ST_DONE;
    is_full = (held_count >= DEPTH);
    is_empty = (held_count == 0);
    case (c.action)
      ACT_CLEAR: begin
        front_ptr = 0;
        back_ptr = 0;
        held_count = 0;
      end
      ACT_PUSH_FRONT: begin
        if (is_full) begin
          r.status = ST_FULL;
        end else begin
          ring_words[front_ptr] = c.value;
          front_ptr = ring_prev(front_ptr);
          held_count++;
        end
      end
      ACT_PUSH_BACK: begin
        if (is_full) begin
          r.status = ST_FULL;
        end else begin
          back_ptr = ring_next(back_ptr);
          ring_words[back_ptr] = c.value;
          held_count++;
        end
      end
      ACT_POP_FRONT: begin
        if (is_empty) begin
          r.status = ST_EMPTY;
        end else begin
          front_ptr = ring_next(front_ptr);
          r.data = ring_words[front_ptr];
          held_count--;
        end
      end
      ACT_PEEK_FRONT: begin
        if (is_empty) r.status = ST_EMPTY;
        else r.data = ring_words[ring_next(front_ptr)];
      end
      ACT_PEEK_BACK: begin
        if (is_empty) r.status = ST_EMPTY;
        else r.data = ring_words[back_ptr];
      end
      default: begin
      end
    endcase
    r.count = held_count[4:0];
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] code, logic [31:0] word);
    cmd_t c;
    c.action = action_t'(code);
    c.value = word;
    return c;
  endfunction

  // mostly random words, now and then an extreme
  function automatic logic [31:0] pick_word();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // send one item, predict it on acceptance, then idle each cycle with the set odds
  task automatic send_item(cmd_t c);
    bit taken;
    taken = 1'b0;
    start <= 1'b1;
    cmd <= c;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      if (taken) pending_results.push_back(deque_predict(c));
      @(posedge clk);
    end
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      cmd <= make_cmd(3'($urandom_range(7)), $urandom);
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
  endtask

  // compare each strobed result with the oldest expectation
  always @(negedge clk) begin
    result_t want;
    if (!rst && valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: data %0d status %0d count %0d",
               result.data, result.status, result.count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.data !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, result.data);
          fail_count++;
        end
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          fail_count++;
        end
        if (result.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, result.count);
          fail_count++;
        end
      end
    end
  end

  // refusals on an empty deque, plus an unused code
  task automatic test_empty_refusals();
    send_item(make_cmd(ACT_POP_FRONT, 32'h1234_5678));
    send_item(make_cmd(ACT_PEEK_FRONT, 32'h0));
    send_item(make_cmd(ACT_PEEK_BACK, 32'hffff_ffff));
    send_item(make_cmd(ACT_SPARE_LO, 32'h5555_5555));
  endtask

  // fill from both ends with extreme words, then push into a full deque
  task automatic test_fill_to_full();
    logic [31:0] words [8];
    words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
              32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'hfffe_0001};
    for (int i = 0; i < 8; i++) begin
      send_item(make_cmd(ACT_PUSH_FRONT, words[i]));
      send_item(make_cmd(ACT_PUSH_BACK, ~words[i]));
    end
    send_item(make_cmd(ACT_PUSH_FRONT, 32'hdead_beef));
    send_item(make_cmd(ACT_PUSH_BACK, 32'hcafe_f00d));
  endtask

  // read back from a full deque and clear it
  task automatic test_peek_pop_clear();
    send_item(make_cmd(ACT_PEEK_FRONT, 32'h0));
    send_item(make_cmd(ACT_POP_FRONT, 32'h0));
    send_item(make_cmd(ACT_CLEAR, 32'hffff_ffff));
  endtask

  // bursts that lean toward filling or draining, with clears and spare codes
  task automatic test_random_traffic(int n_items);
    int          fill_bias;
    int          roll;
    logic [2:0]  code;
    fill_bias = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 24 == 0) fill_bias = $urandom_range(20, 80);
      roll = $urandom_range(99);
      if (roll < 2) begin
        code = ACT_CLEAR;
      end else if (roll < 4) begin
        code = $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      end else if ($urandom_range(99) < fill_bias) begin
        code = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      end else begin
        roll = $urandom_range(99);
        if (roll < 60) code = ACT_POP_FRONT;
        else if (roll < 80) code = ACT_PEEK_FRONT;
        else code = ACT_PEEK_BACK;
      end
      send_item(make_cmd(code, pick_word()));
    end
  endtask

  initial begin
    front_ptr = 0;
    back_ptr = 0;
    held_count = 0;
    for (int i = 0; i < DEPTH; i++) ring_words[i] = '0;

    // reset
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 16;
    test_empty_refusals();
    test_fill_to_full();
    test_peek_pop_clear();
    test_random_traffic(310);

    sender_idle_pct = 60;
    test_random_traffic(310);

    sender_idle_pct = 0;
    test_random_traffic(310);

    // drain and let the pipeline settle
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
